@@ sv/cfq_pkg.sv @@
// Shared types and constants for the circular FIFO with peek.
// No dependencies; imported by cfq_ptr and circular_fifo_with_peek_unit.
`default_nettype none

package cfq_pkg;

	// configuration register
	localparam int unsigned LEN_W     = 10;
	localparam logic [LEN_W-1:0] LEN_RESET = 10'd1023;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned PADDR_W   = 3;
	localparam logic [PADDR_W-3:0] REG_QLEN = 1'b0;

	// operation codes
	localparam logic [1:0] OP_ENQ = 2'd0;
	localparam logic [1:0] OP_DEQ = 2'd1;

	// where the front value comes from after an item
	localparam logic [1:0] FRONT_KEEP = 2'd0;
	localparam logic [1:0] FRONT_VAL  = 2'd1;
	localparam logic [1:0] FRONT_RAM  = 2'd2;

	typedef struct packed {
		logic       accepted;
		logic       empty;
		logic       full;
		logic [1:0] fsel;
		logic       ram_we;
		logic       ram_re;
	} cfq_dec_t;

endpackage

`default_nettype wire

@@ sv/circular_fifo_with_peek_unit.sv @@
// Top level of the circular FIFO with peek: APB length register, command and
// response channels. Depends on cfq_pkg, cfq_ptr and cfq_ram.
//
//  channel | signals                             | direction | meaning
//  cmd     | cmd_valid/cmd_ready, op, value      | in        | enqueue, dequeue, query
//  rsp     | rsp_valid/rsp_ready, accepted,      | out       | status after each item
//          | front_value, rear_value, is_empty,  |           |
//          | is_full                             |           |
//  apb     | psel, penable, pwrite, paddr, ...   | in/out    | queue_length at 0x0
//
// One item per cycle while rsp is not stalled; the response passes through stage 1 (loaded, with the
// slot RAM's registered read for the new front, at the accept edge), then the output reg.
// Reset: pointers at 0, queue_length 1023; the slot RAM is not cleared.
// A queue_length write empties the queue.
// A stalled rsp holds the output register; cmd_ready drops once stage 1 is also full.
`default_nettype none

module circular_fifo_with_peek_unit #(
	parameter int unsigned SLOTS      = 1024,
	parameter int unsigned DATA_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command
	input  wire logic                          cmd_valid,
	output logic                               cmd_ready,
	input  wire logic [1:0]                    op,
	input  wire logic [DATA_WIDTH-1:0]         value,
	// response
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic                               accepted,
	output logic      [DATA_WIDTH-1:0]         front_value,
	output logic      [DATA_WIDTH-1:0]         rear_value,
	output logic                               is_empty,
	output logic                               is_full,
	// APB
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cfq_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [cfq_pkg::APB_DW-1:0]    pwdata,
	output logic      [cfq_pkg::APB_DW-1:0]    prdata,
	output logic                               pready
);
	import cfq_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS);

	logic                  cfg_we;
	logic [LEN_W-1:0]      qlen;
	logic                  reg_hit;
	logic                  cmd_go;
	cfq_dec_t              dec;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rdata;

	logic                  s1_valid_q;
	logic                  s1_move;
	logic                  acc_s1;
	logic                  empty_s1;
	logic                  full_s1;
	logic [1:0]            fsel_s1;
	logic [DATA_WIDTH-1:0] val_s1;
	logic [DATA_WIDTH-1:0] rear_s1;

	logic [DATA_WIDTH-1:0] rear_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] front_nxt;

	logic                  rsp_valid_q;
	logic                  accepted_q;
	logic [DATA_WIDTH-1:0] front_out_q;
	logic [DATA_WIDTH-1:0] rear_out_q;
	logic                  empty_q;
	logic                  full_q;

	// APB
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_QLEN);
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? APB_DW'(qlen) : '0;

	// handshake
	assign s1_move   = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = !s1_valid_q || s1_move;
	assign cmd_go    = cmd_valid && cmd_ready;

	cfq_ptr #(
		.SLOTS (SLOTS)
	) u_ptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_len (pwdata[LEN_W-1:0]),
		.qlen    (qlen),
		.go      (cmd_go),
		.op      (op),
		.dec     (dec),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr)
	);

	cfq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd_go && dec.ram_we),
		.waddr (wr_addr),
		.wdata (value),
		.re    (cmd_go && dec.ram_re),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cmd_go) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_go) begin
			acc_s1   <= dec.accepted;
			empty_s1 <= dec.empty;
			full_s1  <= dec.full;
			fsel_s1  <= dec.fsel;
			val_s1   <= value;
			rear_s1  <= dec.ram_we ? value : rear_q;
			if (dec.ram_we) begin
				rear_q <= value;
			end
		end
	end

	always_comb begin
		case (fsel_s1)
			FRONT_VAL: front_nxt = val_s1;
			FRONT_RAM: front_nxt = rdata;
			default:   front_nxt = front_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			front_q     <= front_nxt;
			accepted_q  <= acc_s1;
			front_out_q <= empty_s1 ? '0 : front_nxt;
			rear_out_q  <= empty_s1 ? '0 : rear_s1;
			empty_q     <= empty_s1;
			full_q      <= full_s1;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign accepted    = accepted_q;
	assign front_value = front_out_q;
	assign rear_value  = rear_out_q;
	assign is_empty    = empty_q;
	assign is_full     = full_q;

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_move |=> s1_valid_q && $stable(fsel_s1) && $stable(val_s1))
		else $error("stage 1 item lost during stall");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> (front_value == '0) && (rear_value == '0))
		else $error("nonzero data on empty queue");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_go |-> !(s1_valid_q && !s1_move))
		else $error("item taken while stage 1 is blocked");
	a_ram_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && (fsel_s1 == FRONT_RAM) |-> !empty_s1 && acc_s1)
		else $error("front fetch for empty or refused item");
`endif

endmodule

`default_nettype wire

@@ sv/cfq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cfq_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/cfq_ptr.sv @@
// Head/tail pointers, length register and per-item decision logic.
// Depends on cfq_pkg.
`default_nettype none

module cfq_ptr #(
	parameter int unsigned SLOTS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cfq_pkg::LEN_W-1:0]   cfg_len,
	output logic      [cfq_pkg::LEN_W-1:0]   qlen,
	input  wire logic                        go,
	input  wire logic [1:0]                  op,
	output cfq_pkg::cfq_dec_t                dec,
	output logic      [$clog2(SLOTS)-1:0]    wr_addr,
	output logic      [$clog2(SLOTS)-1:0]    rd_addr
);
	import cfq_pkg::*;

	localparam int unsigned AW = $clog2(SLOTS);

	logic [LEN_W-1:0] qlen_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [AW-1:0]    last;
	logic [AW-1:0]    head_n;
	logic [AW-1:0]    tail_n;
	logic [AW-1:0]    tail_adv;
	logic [AW-1:0]    head_adv;
	logic             cur_empty;
	logic             cur_full;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx, input logic [AW-1:0] lst);
		return (idx >= lst) ? '0 : idx + AW'(1);
	endfunction

	// ring clamped to SLOTS entries
	always_comb begin
		if (32'(qlen_q) > 32'(SLOTS - 1)) begin
			last = AW'(SLOTS - 1);
		end else begin
			last = AW'(qlen_q);
		end
	end

	assign tail_adv  = adv(tail_q, last);
	assign head_adv  = adv(head_q, last);
	assign cur_empty = (head_q == tail_q);
	assign cur_full  = (tail_adv == head_q);

	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		dec.accepted = 1'b1;
		dec.fsel     = FRONT_KEEP;
		dec.ram_we   = 1'b0;
		dec.ram_re   = 1'b0;
		case (op)
			OP_ENQ: begin
				if (cur_full) begin
					dec.accepted = 1'b0;
				end else begin
					dec.ram_we = 1'b1;
					tail_n     = tail_adv;
					dec.fsel   = cur_empty ? FRONT_VAL : FRONT_KEEP;
				end
			end
			OP_DEQ: begin
				if (cur_empty) begin
					dec.accepted = 1'b0;
				end else begin
					head_n = head_adv;
					// new head slot must be fetched unless the queue drained
					if (head_adv != tail_q) begin
						dec.ram_re = 1'b1;
						dec.fsel   = FRONT_RAM;
					end
				end
			end
			default: begin
			end
		endcase
		dec.empty = (head_n == tail_n);
		dec.full  = (adv(tail_n, last) == head_n);
	end

	assign wr_addr = tail_q;
	assign rd_addr = head_adv;
	assign qlen    = qlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= LEN_RESET;
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_we) begin
			qlen_q <= cfg_len;
			head_q <= '0;
			tail_q <= '0;
		end else if (go) begin
			head_q <= head_n;
			tail_q <= tail_n;
		end
	end

`ifndef ASSERT_OFF
	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> (head_q <= last) && (tail_q <= last))
		else $error("pointer beyond ring end");
	a_enq_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		go && dec.ram_we |=> (head_q != tail_q))
		else $error("queue empty after a write");
	a_we_re_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(dec.ram_we && dec.ram_re))
		else $error("write and read decided for one item");
`endif

endmodule

`default_nettype wire

@@ dv/circular_fifo_with_peek_unit_tb.sv @@
// Testbench for circular_fifo_with_peek_unit: drives commands, APB length
// writes and response backpressure, and checks every status item against a
// behavioral ring model kept here. Depends on cfq_pkg and the unit's RTL.
module circular_fifo_with_peek_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfq_pkg::*;

	localparam int unsigned RING_SLOTS = 1024;
	localparam int unsigned DATA_W = 16;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [PADDR_W-1:0] QLEN_ADDR = {REG_QLEN, 2'b00};
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] front;
		logic [DATA_W-1:0] rear;
		logic              empty;
		logic              full;
	} fifo_status_t;

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_ready;
	logic [1:0]          op;
	logic [DATA_W-1:0]   value;
	logic                rsp_valid;
	logic                rsp_ready;
	logic                accepted;
	logic [DATA_W-1:0]   front_value;
	logic [DATA_W-1:0]   rear_value;
	logic                is_empty;
	logic                is_full;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// ring model
	logic [DATA_W-1:0]   slot_mem [RING_SLOTS];
	int unsigned         head_idx;
	int unsigned         tail_idx;
	logic [LEN_W-1:0]    qlen_cfg;

	fifo_status_t        pending_status[$];
	int unsigned         error_cnt;
	int unsigned         quiet_cycles;
	int unsigned         gap_max;
	int unsigned         stall_max;
	int unsigned         stall_left;
	int unsigned         hold_left;

	circular_fifo_with_peek_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.op          (op),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.accepted    (accepted),
		.front_value (front_value),
		.rear_value  (rear_value),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned ring_last();
		return (qlen_cfg > RING_SLOTS - 1) ? RING_SLOTS - 1 : int'(qlen_cfg);
	endfunction

	function automatic int unsigned ring_next(int unsigned idx);
		return (idx >= ring_last()) ? 0 : idx + 1;
	endfunction

	function automatic int unsigned ring_prev(int unsigned idx);
		return (idx == 0 || idx > ring_last()) ? ring_last() : idx - 1;
	endfunction

	// applies one command to the ring model and returns the status it yields
	function automatic fifo_status_t next_status(logic [1:0] cmd, logic [DATA_W-1:0] data);
		fifo_status_t st;
		st.ok = 1'b1;
		if (cmd == OP_ENQ) begin
			if (ring_next(tail_idx) == head_idx) begin
				st.ok = 1'b0;
			end else begin
				slot_mem[tail_idx] = data;
				tail_idx = ring_next(tail_idx);
			end
		end else if (cmd == OP_DEQ) begin
			if (head_idx == tail_idx) begin
				st.ok = 1'b0;
			end else begin
				head_idx = ring_next(head_idx);
			end
		end
		st.empty = (head_idx == tail_idx);
		st.full = (ring_next(tail_idx) == head_idx);
		st.front = st.empty ? '0 : slot_mem[head_idx];
		st.rear = st.empty ? '0 : slot_mem[ring_prev(tail_idx)];
		return st;
	endfunction

	function automatic void report_error(string what);
		error_cnt++;
		if (error_cnt <= MAX_REPORTS) begin
			$display("%0t ns: %s", $realtime, what);
		end
	endfunction

	function automatic int unsigned pick_idle();
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return 3;
			default: return 17;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// result check first, then predict the item taken at this edge
	always @(posedge clk) begin : status_check
		fifo_status_t got;
		fifo_status_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got = {accepted, front_value, rear_value, is_empty, is_full};
				stall_left = $urandom_range(0, stall_max);
				if (pending_status.size() == 0) begin
					report_error("status item with nothing pending");
				end else begin
					want = pending_status.pop_front();
					if (got !== want) begin
						report_error($sformatf({"status mismatch: expected ok=%0b front=%h ",
							"rear=%h empty=%0b full=%0b, got ok=%0b front=%h rear=%h ",
							"empty=%0b full=%0b"},
							want.ok, want.front, want.rear, want.empty, want.full,
							got.ok, got.front, got.rear, got.empty, got.full));
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				pending_status.push_back(next_status(op, value));
			end
		end
	end

	// response side: long hold-off first, then the per-item stall
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL circular_fifo_with_peek_unit");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [DATA_W-1:0] data);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		op <= cmd;
		value <= data;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write queue_length, which also empties the ring, then read it back
	task automatic write_queue_length(input logic [LEN_W-1:0] len);
		logic [APB_DW-1:0] rd;
		wait_idle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= QLEN_ADDR;
		pwdata <= APB_DW'(len);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		qlen_cfg = len;
		head_idx = 0;
		tail_idx = 0;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DW'(len)) begin
			report_error($sformatf("queue_length readback: expected %h, got %h",
				APB_DW'(len), rd));
		end
	endtask

	// reset length: empty-queue refusals, spare op code, both value extremes
	task automatic test_reset_defaults();
		gap_max = 5;
		stall_max = 5;
		send_item(OP_QUERY, '0);
		send_item(OP_DEQ, '1);
		send_item(OP_SPARE, '1);
		send_item(OP_ENQ, '0);
		send_item(OP_ENQ, '1);
		send_item(OP_QUERY, 16'h5a5a);
		send_item(OP_SPARE, 16'h1234);
		send_item(OP_DEQ, '0);
		send_item(OP_DEQ, '0);
		send_item(OP_DEQ, '0);
	endtask

	// smallest rings: one entry, zero length (always full and empty), wrap at two
	task automatic test_length_limits();
		write_queue_length(10'd1);
		send_item(OP_ENQ, 16'h1234);
		send_item(OP_ENQ, 16'hbeef);
		send_item(OP_DEQ, '0);
		send_item(OP_DEQ, '0);
		write_queue_length(10'd0);
		send_item(OP_ENQ, 16'h8001);
		send_item(OP_DEQ, '0);
		send_item(OP_QUERY, '0);
		write_queue_length(10'd2);
		send_item(OP_ENQ, 16'haaaa);
		send_item(OP_ENQ, 16'h5555);
		send_item(OP_ENQ, 16'hffff);
		send_item(OP_DEQ, '0);
		send_item(OP_ENQ, 16'h0f0f);
		send_item(OP_DEQ, '0);
		send_item(OP_DEQ, '0);
		send_item(OP_DEQ, '0);
	endtask

	// response side holds off while commands keep coming, so cmd_ready drops
	task automatic test_backpressure();
		write_queue_length(10'd8);
		gap_max = 0;
		stall_max = 0;
		hold_left = 300;
		repeat (24) send_item(OP_ENQ, random_word());
		repeat (12) send_item(OP_DEQ, random_word());
	endtask

	task automatic test_random_traffic();
		logic [LEN_W-1:0] lengths [9] = '{10'd5, 10'd1, 10'd3, 10'd0, 10'd12, 10'd2,
			10'd1023, 10'd7, 10'd64};
		int unsigned enq_pct [4] = '{80, 20, 60, 35};
		int unsigned pick;
		logic [1:0] cmd;
		foreach (lengths[i]) begin
			write_queue_length(lengths[i]);
			foreach (enq_pct[j]) begin
				gap_max = pick_idle();
				stall_max = pick_idle();
				repeat (20) begin
					pick = $urandom_range(0, 99);
					if (pick < enq_pct[j]) cmd = OP_ENQ;
					else if (pick < 90) cmd = OP_DEQ;
					else if (pick < 96) cmd = OP_QUERY;
					else cmd = OP_SPARE;
					send_item(cmd, random_word());
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		op = OP_ENQ;
		value = '0;
		rsp_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		qlen_cfg = LEN_RESET;
		head_idx = 0;
		tail_idx = 0;
		error_cnt = 0;
		quiet_cycles = 0;
		gap_max = 0;
		stall_max = 0;
		stall_left = 0;
		hold_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_length_limits();
		test_backpressure();
		test_random_traffic();

		wait_idle();
		repeat (8) @(posedge clk);
		if (error_cnt == 0 && pending_status.size() == 0) begin
			$display("PASS circular_fifo_with_peek_unit");
		end else begin
			$display("FAIL circular_fifo_with_peek_unit");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/cfq_pkg.sv
sv/cfq_ram.sv
sv/cfq_ptr.sv
sv/circular_fifo_with_peek_unit.sv
dv/circular_fifo_with_peek_unit_tb.sv
